// File: rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int LEN_W     = 32;
	localparam int BYTE_BITS = 8;
	localparam int CNT_W     = 3;

	// header sizes in bytes, big-endian length
	localparam logic [CNT_W-1:0] TEXT_HDR_BYTES = 3'd2;
	localparam logic [CNT_W-1:0] BIN_HDR_BYTES  = 3'd4;

	localparam logic [7:0] ASCII_MAX = 8'd127;
	localparam logic [7:0] SEPARATOR = 8'h3A;

	localparam logic [15:0] MAX_TEXT_LEN_RST = 16'hFFFF;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_AUTO_BIN  = 2'd0;
	localparam logic [1:0] REG_AUTO_TEXT = 2'd1;
	localparam logic [1:0] REG_MAX_TEXT  = 2'd2;

	typedef enum logic [1:0] {
		ACT_DATA   = 2'd0,
		ACT_TEXT   = 2'd1,
		ACT_BINARY = 2'd2
	} lpd_action_t;

	typedef enum logic [2:0] {
		KIND_HEADER = 3'd0,
		KIND_TAG    = 3'd1,
		KIND_SEP    = 3'd2,
		KIND_VALUE  = 3'd3,
		KIND_BINARY = 3'd4
	} lpd_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_LENGTH = 2'd1,
		ERR_ASCII  = 2'd2
	} lpd_err_t;

	typedef struct packed {
		logic        auto_bin;
		logic        auto_text;
		logic [15:0] max_text_len;
	} lpd_cfg_t;

	typedef struct packed {
		logic [7:0] byte_out;
		lpd_kind_t  kind;
		logic       done;
		logic       was_bin;
		logic       colon;
		lpd_err_t   err;
		logic       mode_now;
	} lpd_result_t;

endpackage

// File: rtl/lpd_core.sv
// ----------------------------------------------------------------------------
// lpd_core
// Frame state and per-byte decode; one item per accepted transfer.
// ----------------------------------------------------------------------------
module lpd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          action,
	input  logic [7:0]          data_byte,
	input  lpd_pkg::lpd_cfg_t   cfg,
	output lpd_pkg::lpd_result_t res
);

	logic                        mode_q, mode_d;
	logic                        in_body_q, in_body_d;
	logic [lpd_pkg::CNT_W-1:0]   hdr_cnt_q, hdr_cnt_d;
	logic [lpd_pkg::LEN_W-1:0]   len_acc_q, len_acc_d;
	logic [lpd_pkg::LEN_W-1:0]   remain_q, remain_d;
	logic                        colon_q, colon_d;
	logic                        non_ascii_q, non_ascii_d;

	always_comb begin
		logic                      clr;
		logic                      fin;
		logic [lpd_pkg::CNT_W-1:0] hsize;
		clr         = 1'b0;
		fin         = 1'b0;
		hsize       = mode_q ? lpd_pkg::BIN_HDR_BYTES : lpd_pkg::TEXT_HDR_BYTES;
		mode_d      = mode_q;
		in_body_d   = in_body_q;
		hdr_cnt_d   = hdr_cnt_q;
		len_acc_d   = len_acc_q;
		remain_d    = remain_q;
		colon_d     = colon_q;
		non_ascii_d = non_ascii_q;
		res.byte_out = 8'd0;
		res.kind     = lpd_pkg::KIND_HEADER;
		res.done     = 1'b0;
		res.was_bin  = 1'b0;
		res.colon    = 1'b0;
		res.err      = lpd_pkg::ERR_NONE;

		case (action)
			lpd_pkg::ACT_TEXT, lpd_pkg::ACT_BINARY: begin
				mode_d = (action == lpd_pkg::ACT_BINARY);
				clr    = 1'b1;
			end
			lpd_pkg::ACT_DATA: begin
				res.byte_out = data_byte;
				if (!in_body_q) begin
					len_acc_d = (len_acc_q << lpd_pkg::BYTE_BITS)
						| {{(lpd_pkg::LEN_W-8){1'b0}}, data_byte};
					hdr_cnt_d = hdr_cnt_q + 3'd1;
					if (hdr_cnt_d >= hsize) begin
						if (!mode_q && len_acc_d > {16'd0, cfg.max_text_len}) begin
							res.err = lpd_pkg::ERR_LENGTH;
							clr     = 1'b1;
						end else if (len_acc_d == '0) begin
							res.done    = 1'b1;
							res.was_bin = mode_q;
							fin         = 1'b1;
						end else begin
							in_body_d   = 1'b1;
							remain_d    = len_acc_d;
							hdr_cnt_d   = '0;
							len_acc_d   = '0;
							colon_d     = 1'b0;
							non_ascii_d = 1'b0;
						end
					end
				end else if (mode_q) begin
					res.kind = lpd_pkg::KIND_BINARY;
					remain_d = remain_q - 32'd1;
					if (remain_d == '0) begin
						res.done    = 1'b1;
						res.was_bin = 1'b1;
						fin         = 1'b1;
					end
				end else begin
					// only the first colon of the body separates tag and value
					if (!colon_q && data_byte == lpd_pkg::SEPARATOR) begin
						res.kind = lpd_pkg::KIND_SEP;
						colon_d  = 1'b1;
					end else begin
						res.kind = colon_q ? lpd_pkg::KIND_VALUE : lpd_pkg::KIND_TAG;
					end
					if (data_byte > lpd_pkg::ASCII_MAX)
						non_ascii_d = 1'b1;
					remain_d = remain_q - 32'd1;
					if (remain_d == '0) begin
						res.done  = 1'b1;
						res.colon = colon_d;
						if (non_ascii_d) begin
							res.err = lpd_pkg::ERR_ASCII;
							clr     = 1'b1;
						end else begin
							fin = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		// good frame: optional automatic mode change
		if (fin) begin
			if (mode_q)
				mode_d = cfg.auto_text ? 1'b0 : 1'b1;
			else
				mode_d = cfg.auto_bin;
		end
		if (clr || fin) begin
			in_body_d   = 1'b0;
			hdr_cnt_d   = '0;
			len_acc_d   = '0;
			remain_d    = '0;
			colon_d     = 1'b0;
			non_ascii_d = 1'b0;
		end
		res.mode_now = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			in_body_q   <= 1'b0;
			hdr_cnt_q   <= '0;
			len_acc_q   <= '0;
			remain_q    <= '0;
			colon_q     <= 1'b0;
			non_ascii_q <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_d;
			in_body_q   <= in_body_d;
			hdr_cnt_q   <= hdr_cnt_d;
			len_acc_q   <= len_acc_d;
			remain_q    <= remain_d;
			colon_q     <= colon_d;
			non_ascii_q <= non_ascii_d;
		end
	end

endmodule

// File: rtl/length_prefixed_deframer_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top
// Deframes big-endian length-prefixed text and binary frames byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser = action (data byte, force text, force binary),
//   tdata = received byte. Each input transfer yields exactly one output
//   transfer: tdata carries the byte and frame status, tuser the byte kind,
//   tlast marks the transfer that completed a frame.
//   Output is valid in the cycle after the input transfer. Throughput is one
//   byte per cycle unless the receiver stalls; the frame counters update in a
//   single pass and the output register is the only stage.
//   s_axis_tready is low only while a result is held and the receiver is
//   stalling; the held result stays unchanged until it is taken.
//   Reset clears the frame state, selects text mode, empties the output
//   register and sets the registers to: auto switches off, max text length
//   65535. Registers (APB, byte address): 0x0 auto_binary_after_text,
//   0x4 auto_text_after_binary, 0x8 max_text_length. Write them only while
//   the block is idle.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] byte_out, [8] frame_was_binary, [9] colon_found,
	// [11:10] error_code, [12] mode_now, [15:13] zero
	output logic [15:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,   // [2:0] byte_kind
	output logic        m_axis_tlast,   // frame_done
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lpd_pkg::lpd_cfg_t    cfg_q;
	lpd_pkg::lpd_result_t res;
	lpd_pkg::lpd_result_t out_q;
	logic                 out_valid_q;
	logic                 accept;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_bin     <= 1'b0;
			cfg_q.auto_text    <= 1'b0;
			cfg_q.max_text_len <= lpd_pkg::MAX_TEXT_LEN_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				lpd_pkg::REG_AUTO_BIN:  cfg_q.auto_bin     <= pwdata[0];
				lpd_pkg::REG_AUTO_TEXT: cfg_q.auto_text    <= pwdata[0];
				lpd_pkg::REG_MAX_TEXT:  cfg_q.max_text_len <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			lpd_pkg::REG_AUTO_BIN:  prdata = {31'd0, cfg_q.auto_bin};
			lpd_pkg::REG_AUTO_TEXT: prdata = {31'd0, cfg_q.auto_text};
			lpd_pkg::REG_MAX_TEXT:  prdata = {16'd0, cfg_q.max_text_len};
			default:                prdata = 32'd0;
		endcase
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	lpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (s_axis_tuser),
		.data_byte (s_axis_tdata),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_q.mode_now, out_q.err, out_q.colon,
		out_q.was_bin, out_q.byte_out};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.done;

endmodule

// File: rtl/lpd_checker.sv
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module lpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled result must stay presented
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transfer dropped while stalled");

	// every input transfer presents a result on the next cycle
	a_in_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("input transfer without a result");

	// a length error never completes a frame
	a_len_err_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[11:10] == 2'd1 |-> !m_axis_tlast)
		else $error("length error marked as frame end");

	// colon_found only at the end of a text frame
	a_colon_text_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tlast && !m_axis_tdata[8])
		else $error("colon flag outside text frame end");

	// binary body bytes that do not end a frame leave binary mode in force
	a_bin_body_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == 3'd4 && !m_axis_tlast |-> m_axis_tdata[12])
		else $error("binary body byte reported in text mode");

endmodule

bind length_prefixed_deframer_top lpd_checker u_lpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
